@@ sv/lru_pkg.sv @@
// Shared types and constants of the recency list block.
// Depends on nothing; every other file imports it.
package lru_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;
	localparam int RID_W    = 4;
	localparam int LENGTH_W = 5;
	localparam int ENTRY_W  = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 3'd0,
		ACT_MOVE   = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_POP    = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOT_IN   = 2'd2,
		ST_ALREADY  = 2'd3
	} status_t;

	// What every cell of the order chain does at a clock edge.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_PUSH   = 2'd1,
		CELL_MOVE   = 2'd2,
		CELL_UNLINK = 2'd3
	} cell_op_t;

endpackage

@@ sv/lru_cell.sv @@
// One position of the recency order: holds the slot id stored there.
// Depends on lru_pkg (cell_op_t).
module lru_cell #(
	parameter int IDW = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lru_pkg::cell_op_t op,
	input  logic [IDW-1:0]   key,
	input  logic             valid,
	input  logic             nxt_valid,
	input  logic [IDW-1:0]   prev_id,
	input  logic [IDW-1:0]   next_id,
	input  logic             found_in,
	input  logic [IDW-1:0]   tail_in,
	output logic [IDW-1:0]   id_q,
	output logic             found_out,
	output logic [IDW-1:0]   tail_out
);
	import lru_pkg::*;

	logic           match;
	logic [IDW-1:0] id_d;

	assign match     = valid && (id_q == key);
	assign found_out = found_in | match;
	// the last valid position reports its id down the chain
	assign tail_out  = (valid && !nxt_valid) ? id_q : tail_in;

	always_comb begin
		id_d = id_q;
		case (op)
			CELL_PUSH: begin
				id_d = prev_id;
			end
			CELL_MOVE: begin
				if (!found_in) begin
					id_d = prev_id;
				end
			end
			CELL_UNLINK: begin
				if (found_in || match) begin
					id_d = next_id;
				end
			end
			default: begin
				id_d = id_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= '0;
		end else begin
			id_q <= id_d;
		end
	end

endmodule

@@ sv/lru_chain.sv @@
// Row of order cells, head at position 0; gives hit and tail id for a key.
// Depends on lru_pkg and lru_cell.
module lru_chain #(
	parameter int SLOTS = lru_pkg::SLOTS_DEF,
	parameter int IDW   = $clog2(SLOTS),
	parameter int CW    = $clog2(SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lru_pkg::cell_op_t op,
	input  logic [IDW-1:0]    key,
	input  logic [CW-1:0]     count,
	output logic              hit,
	output logic [IDW-1:0]    tail_id
);
	import lru_pkg::*;

	logic [IDW-1:0] ids   [SLOTS];
	logic [SLOTS:0] found;
	logic [IDW-1:0] tails [SLOTS+1];
	logic [SLOTS:0] valid;

	assign found[0] = 1'b0;
	assign tails[0] = '0;
	assign valid[SLOTS] = 1'b0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic [IDW-1:0] prev_id;
		logic [IDW-1:0] next_id;

		assign valid[i] = (count > CW'(i));

		if (i == 0) begin : g_head
			assign prev_id = key;
		end else begin : g_mid
			assign prev_id = ids[i-1];
		end

		if (i == SLOTS - 1) begin : g_last
			assign next_id = '0;
		end else begin : g_inner
			assign next_id = ids[i+1];
		end

		lru_cell #(.IDW(IDW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.key       (key),
			.valid     (valid[i]),
			.nxt_valid (valid[i+1]),
			.prev_id   (prev_id),
			.next_id   (next_id),
			.found_in  (found[i]),
			.tail_in   (tails[i]),
			.id_q      (ids[i]),
			.found_out (found[i+1]),
			.tail_out  (tails[i+1])
		);
	end

	assign hit     = found[SLOTS];
	assign tail_id = tails[SLOTS];

endmodule

@@ sv/lru_recency_list_core.sv @@
// Recency list top level: request register, order chain, count and data store.
// Depends on lru_pkg and lru_chain.
// An accepted request waits in the request register until the chain update fires,
// which is held back while a stalled result still holds the result register.
// One request at a time: in_stall stays high until the chain update fires.
// Reset (arst_n low, asynchronous): list empty, count zero, no result pending.
module lru_recency_list_core #(
	parameter int SLOTS      = lru_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH = lru_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lru_pkg::ACTION_W-1:0] action,
	input  logic [lru_pkg::ENTRY_W-1:0]  entry_id,
	input  logic [DATA_WIDTH-1:0]        entry_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lru_pkg::STATUS_W-1:0] status,
	output logic [lru_pkg::RID_W-1:0]    result_id,
	output logic [DATA_WIDTH-1:0]        result_data,
	output logic [lru_pkg::LENGTH_W-1:0] length
);
	import lru_pkg::*;

	localparam int IDW     = $clog2(SLOTS);
	localparam int CW      = $clog2(SLOTS + 1);
	localparam int ID_VALS = 1 << ENTRY_W;

	// Slot ids wrap modulo SLOTS: a constant table over the narrow id field.
	logic [IDW-1:0] id_tab [ID_VALS];
	for (genvar k = 0; k < ID_VALS; k++) begin : g_idtab
		assign id_tab[k] = IDW'(k % SLOTS);
	end

	// Request register and control.
	logic                    busy_q;
	logic [ACTION_W-1:0]     act_q;
	logic [IDW-1:0]          id_q;
	logic [DATA_WIDTH-1:0]   data_q;
	logic [CW-1:0]           count_q;

	// Result register.
	logic                    out_valid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [IDW-1:0]          rid_q;
	logic [CW-1:0]           len_q;
	logic [DATA_WIDTH-1:0]   rdata_q;

	// Data store, written on insert, read for pop and read.
	logic [DATA_WIDTH-1:0]   mem [SLOTS];

	logic                    accept;
	logic                    fire;
	logic                    hit;
	logic [IDW-1:0]          tail_id;
	cell_op_t                op_c;
	cell_op_t                op;
	logic [CW-1:0]           count_d;
	logic [STATUS_W-1:0]     status_c;
	logic [IDW-1:0]          rid_c;
	logic                    mem_we;
	logic                    mem_rd;
	logic [IDW-1:0]          rd_addr;

	// Hold new requests while the current one works through the chain.
	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	// Advance only when the result register is free or being emptied.
	assign fire     = busy_q && !(out_valid_q && out_stall);
	assign op       = fire ? op_c : CELL_HOLD;

	lru_chain #(
		.SLOTS (SLOTS),
		.IDW   (IDW),
		.CW    (CW)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.key     (id_q),
		.count   (count_q),
		.hit     (hit),
		.tail_id (tail_id)
	);

	// Decode the request against the chain's hit and tail.
	always_comb begin
		op_c     = CELL_HOLD;
		count_d  = count_q;
		status_c = ST_OK;
		rid_c    = id_q;
		mem_we   = 1'b0;
		mem_rd   = 1'b0;
		rd_addr  = id_q;
		case (act_q)
			ACT_INSERT: begin
				if (hit) begin
					status_c = ST_ALREADY;
				end else begin
					// a slot not yet listed always leaves room at the head
					op_c    = CELL_PUSH;
					count_d = count_q + CW'(1);
					mem_we  = 1'b1;
				end
			end
			ACT_MOVE: begin
				if (!hit) begin
					status_c = ST_NOT_IN;
				end else begin
					op_c = CELL_MOVE;
				end
			end
			ACT_REMOVE: begin
				if (!hit) begin
					status_c = ST_NOT_IN;
				end else begin
					op_c    = CELL_UNLINK;
					count_d = count_q - CW'(1);
				end
			end
			ACT_POP: begin
				if (count_q == '0) begin
					status_c = ST_EMPTY;
					rid_c    = '0;
				end else begin
					// drop the tail by shrinking the count; cells keep their ids
					rid_c   = tail_id;
					rd_addr = tail_id;
					mem_rd  = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			ACT_READ: begin
				mem_rd = 1'b1;
			end
			default: begin
				status_c = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			id_q   <= id_tab[entry_id];
			data_q <= entry_data;
		end
	end

	// Result payload and data store.
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_c;
			rid_q    <= rid_c;
			len_q    <= count_d;
			if (mem_we) begin
				mem[id_q] <= data_q;
			end
			if (mem_rd) begin
				rdata_q <= mem[rd_addr];
			end else begin
				rdata_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_id   = RID_W'(rid_q);
	assign result_data = rdata_q;
	assign length      = LENGTH_W'(len_q);

endmodule
